// ===== rtl/core/pca_feature_projection_unit_assert.svh =====
// Assertion macros for the PCA feature projection unit.
// Needs clk_i and rst_ni in the scope of use.
`ifndef PCA_FEATURE_PROJECTION_UNIT_ASSERT_SVH
`define PCA_FEATURE_PROJECTION_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define PFP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pfp assertion failed");

// Next-cycle implication, checked outside reset
`define PFP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pfp assertion failed");

`endif

// ===== rtl/core/pfp_pkg.sv =====
// Shared types, sizes and helpers for the PCA feature projection unit.
// No dependencies.
package pfp_pkg;
  localparam int MaxInOrder  = 32;
  localparam int MaxOutOrder = 16;
  localparam int FracBits    = 16;
  localparam int AccW        = 48;
  localparam int ColW        = $clog2(MaxInOrder);
  localparam int RowW        = $clog2(MaxOutOrder);
  localparam int MatDepth    = MaxInOrder * MaxOutOrder;
  localparam int MatAddrW    = $clog2(MatDepth);
  localparam int DivNumW     = 33 + FracBits;

  localparam logic [1:0] ModeMean    = 2'd0;
  localparam logic [1:0] ModeStd     = 2'd1;
  localparam logic [1:0] ModeMatrix  = 2'd2;
  localparam logic [1:0] ModeFeature = 2'd3;

  localparam logic CfgInOrder  = 1'b0;
  localparam logic CfgOutOrder = 1'b1;

  // divider request bundle
  typedef struct packed {
    logic               start;
    logic [DivNumW-1:0] num;
    logic [31:0]        den;
  } div_req_t;

  // saturate a 49-bit sum to the 48-bit accumulator range
  function automatic logic [AccW-1:0] sat_acc(input logic [AccW:0] v);
    logic [AccW-1:0] r;
    if (v[AccW] != v[AccW-1]) begin
      r = v[AccW] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
    end else begin
      r = v[AccW-1:0];
    end
    return r;
  endfunction

  // saturate an accumulator to 32 bits
  function automatic logic [31:0] sat_out(input logic [AccW-1:0] v);
    logic [31:0] r;
    if (v[AccW-1] && !(&v[AccW-2:31])) begin
      r = 32'h8000_0000;
    end else if (!v[AccW-1] && (|v[AccW-2:31])) begin
      r = 32'h7FFF_FFFF;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction
endpackage

// ===== rtl/core/pfp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pfp_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// ===== rtl/core/pfp_cell.sv =====
// One accumulator cell of the rotating component ring.
// Depends on pfp_pkg.
module pfp_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     shift_en_i,
  input  logic [pfp_pkg::AccW-1:0] acc_i,
  output logic [pfp_pkg::AccW-1:0] acc_o
);
  import pfp_pkg::*;

  logic [AccW-1:0] acc_q;

  // take the neighbor's value on each ring step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (shift_en_i) begin
      acc_q <= acc_i;
    end
  end

  assign acc_o = acc_q;
endmodule

// ===== rtl/core/pfp_div.sv =====
// Unsigned restoring divider, one quotient bit per cycle.
// Depends on pfp_pkg.
module pfp_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pfp_pkg::div_req_t           req_i,
  output logic                        done_o,
  output logic [pfp_pkg::DivNumW-1:0] quo_o
);
  import pfp_pkg::*;

  localparam int CntW = $clog2(DivNumW + 1);

  logic [31:0]        rem_q, den_q;
  logic [DivNumW-1:0] num_q, quo_q;
  logic [CntW-1:0]    cnt_q;
  logic               busy_q, done_q;
  logic [32:0]        trial;
  logic               qbit;

  // shift in the next dividend bit and try a subtract
  assign trial = {rem_q, num_q[DivNumW-1]};
  assign qbit  = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == CntW'(DivNumW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      den_q <= req_i.den;
      num_q <= req_i.num;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= qbit ? 32'(trial - {1'b0, den_q}) : trial[31:0];
      num_q <= {num_q[DivNumW-2:0], 1'b0};
      quo_q <= {quo_q[DivNumW-2:0], qbit};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
endmodule

// ===== rtl/core/pca_feature_projection_unit.sv =====
// PCA feature projection unit: load beats write the mean, deviation and matrix
// tables directly. A feature beat passes through the table reads, the
// bit-serial standardizing divider (skipped when the deviation is zero), then
// 16 ring steps, each a matrix read, a 32x32 multiply and an accumulate,
// through a ring of 16 accumulator cells. The beat that closes a frame adds 16
// more ring steps to unload and clear the accumulators, with a result beat on
// each step below the output order while the output side keeps up.
// Depends on pfp_pkg, pfp_ram, pfp_cell, pfp_div and the assertion header.
module pca_feature_projection_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_index_i,
  input  logic [5:0]                  cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  mode_i,
  input  logic [pfp_pkg::RowW-1:0]    row_index_i,
  input  logic [pfp_pkg::ColW-1:0]    column_index_i,
  input  logic signed [31:0]          value_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [pfp_pkg::RowW-1:0]    component_index_o,
  output logic signed [31:0]          component_value_o,
  output logic                        last_of_frame_o
);
  import pfp_pkg::*;
  `include "pca_feature_projection_unit_assert.svh"

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StRd   = 3'd1;
  localparam logic [2:0] StDiv  = 3'd2;
  localparam logic [2:0] StMa   = 3'd3;
  localparam logic [2:0] StMm   = 3'd4;
  localparam logic [2:0] StMc   = 3'd5;
  localparam logic [2:0] StOut  = 3'd6;

  logic [2:0]       state_q, state_d;
  logic [5:0]       in_order_q;
  logic [4:0]       out_order_q;
  logic [5:0]       n_in;
  logic [4:0]       n_out;
  logic [ColW-1:0]  col_q;
  logic [31:0]      x_q, s_q;
  logic             last_q, neg_q;
  logic [RowW:0]    k_q;
  logic signed [63:0] p_q;
  logic             out_valid_q, out_last_q;
  logic [RowW-1:0]  out_idx_q;
  logic [31:0]      out_val_q;

  logic             accept;
  logic [31:0]      mean_rd, dev_rd, mat_rd;
  div_req_t         div_req;
  logic             div_done;
  logic [DivNumW-1:0] quo;
  logic [32:0]      diff, diff_mag;
  logic [31:0]      dev_mag;
  logic             k_active, out_free, shift_en, last_step;
  logic [AccW-1:0]  head_new, prod_sh;
  logic [AccW-1:0]  ring [MaxOutOrder];

  // effective orders
  always_comb begin
    n_in  = (in_order_q == '0) ? 6'd1 :
            (in_order_q > 6'(MaxInOrder)) ? 6'(MaxInOrder) : in_order_q;
    n_out = (out_order_q == '0) ? 5'd1 :
            (out_order_q > 5'(MaxOutOrder)) ? 5'(MaxOutOrder) : out_order_q;
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_order_q  <= 6'd32;
      out_order_q <= 5'd16;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgInOrder:  in_order_q  <= cfg_wdata_i;
        CfgOutOrder: out_order_q <= cfg_wdata_i[4:0];
        default: ;
      endcase
    end
  end

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;

  // tables
  pfp_ram #(.Width(32), .Depth(MaxInOrder)) u_mean (
    .clk_i, .we_i(accept && mode_i == ModeMean), .waddr_i(column_index_i),
    .wdata_i(value_i), .raddr_i(column_index_i), .rdata_o(mean_rd)
  );
  pfp_ram #(.Width(32), .Depth(MaxInOrder)) u_dev (
    .clk_i, .we_i(accept && mode_i == ModeStd), .waddr_i(column_index_i),
    .wdata_i(value_i), .raddr_i(column_index_i), .rdata_o(dev_rd)
  );
  pfp_ram #(.Width(32), .Depth(MatDepth)) u_mat (
    .clk_i, .we_i(accept && mode_i == ModeMatrix),
    .waddr_i({row_index_i, column_index_i}), .wdata_i(value_i),
    .raddr_i({k_q[RowW-1:0], col_q}), .rdata_o(mat_rd)
  );

  // standardize: magnitudes into the divider
  always_comb begin
    diff     = {x_q[31], x_q} - {mean_rd[31], mean_rd};
    diff_mag = diff[32] ? 33'(-diff) : diff;
    dev_mag  = dev_rd[31] ? 32'(-dev_rd) : dev_rd;
    div_req.start = (state_q == StRd) && (dev_rd != '0);
    div_req.num   = {diff_mag, {FracBits{1'b0}}};
    div_req.den   = dev_mag;
  end

  pfp_div u_div (
    .clk_i, .rst_ni, .req_i(div_req), .done_o(div_done), .quo_o(quo)
  );

  // ring control
  assign k_active  = (k_q < n_out);
  assign out_free  = !out_valid_q || out_ready_i;
  assign last_step = (k_q == (RowW + 1)'(MaxOutOrder - 1));
  assign prod_sh   = AccW'(p_q >>> FracBits);
  assign shift_en  = (state_q == StMc) || (state_q == StOut && out_free);

  always_comb begin
    if (state_q == StOut) begin
      head_new = '0;
    end else if (k_active) begin
      head_new = sat_acc({ring[0][AccW-1], ring[0]} + {prod_sh[AccW-1], prod_sh});
    end else begin
      head_new = ring[0];
    end
  end

  // accumulator ring: cell 0 is the head
  for (genvar i = 0; i < MaxOutOrder; i++) begin : g_ring
    pfp_cell u_cell (
      .clk_i, .rst_ni, .shift_en_i(shift_en),
      .acc_i((i == MaxOutOrder - 1) ? head_new : ring[(i + 1) % MaxOutOrder]),
      .acc_o(ring[i])
    );
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (accept && mode_i == ModeFeature && {1'b0, column_index_i} < n_in) begin
        state_d = StRd;
      end
      StRd:   state_d = (dev_rd == '0) ? StMa : StDiv;
      StDiv:  if (div_done) state_d = StMa;
      StMa:   state_d = StMm;
      StMm:   state_d = StMc;
      StMc:   if (last_step) begin
        state_d = last_q ? StOut : StIdle;
      end else begin
        state_d = StMa;
      end
      StOut:  if (out_free && last_step) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (shift_en) begin
        k_q <= last_step ? '0 : k_q + 1'b1;
      end
      if (state_q == StOut && out_free && k_active) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q    <= value_i;
      col_q  <= column_index_i;
      last_q <= ({1'b0, column_index_i} == 6'(n_in - 1'b1));
    end
    if (state_q == StRd) begin
      neg_q <= diff[32] ^ dev_rd[31];
      if (dev_rd == '0) begin
        s_q <= diff[32] ? 32'h8000_0000 : ((diff == '0) ? 32'h0 : 32'h7FFF_FFFF);
      end
    end
    if (div_done) begin
      if (neg_q) begin
        s_q <= (quo > DivNumW'(33'h0_8000_0000)) ? 32'h8000_0000 : 32'(-quo[32:0]);
      end else begin
        s_q <= (quo > DivNumW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : quo[31:0];
      end
    end
    if (state_q == StMm) begin
      p_q <= $signed(s_q) * $signed(mat_rd);
    end
    if (state_q == StOut && out_free && k_active) begin
      out_idx_q  <= k_q[RowW-1:0];
      out_val_q  <= sat_out(ring[0]);
      out_last_q <= (k_q == n_out - 1'b1);
    end
  end

  assign out_valid_o       = out_valid_q;
  assign component_index_o = out_idx_q;
  assign component_value_o = out_val_q;
  assign last_of_frame_o   = out_last_q;

  // checks
  `PFP_ASSERT_NOW(a_last_idx, out_valid_q && out_last_q,
                  {1'b0, out_idx_q} == n_out - 1'b1)
  `PFP_ASSERT_NOW(a_busy_no_accept, state_q != StIdle, !in_ready_o)
  `PFP_ASSERT_NEXT(a_div_done_state, div_done, state_q == StMa)
  `PFP_ASSERT_NOW(a_k_range, state_q != StIdle, k_q < (RowW + 1)'(MaxOutOrder))
endmodule

// ===== dv/pfp_checker.sv =====
// Checker for the PCA feature projection unit: watches both channels and the
// config port, predicts projection results and compares them. Needs pfp_pkg.
`timescale 1ns / 1ps

module pfp_checker (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic                     cfg_index_i,
  input  logic [5:0]               cfg_wdata_i,
  input  logic                     in_valid_i,
  input  logic                     in_ready_i,
  input  logic [1:0]               mode_i,
  input  logic [pfp_pkg::RowW-1:0] row_index_i,
  input  logic [pfp_pkg::ColW-1:0] column_index_i,
  input  logic signed [31:0]       value_i,
  input  logic                     out_valid_i,
  input  logic                     out_ready_i,
  input  logic [pfp_pkg::RowW-1:0] component_index_i,
  input  logic signed [31:0]       component_value_i,
  input  logic                     last_of_frame_i,
  output int                       fail_count_o,
  output int                       pending_o,
  output int                       result_count_o
);
  import pfp_pkg::*;

  typedef struct packed {
    logic [RowW-1:0] idx;
    logic [31:0]     val;
    logic            last;
  } proj_t;

  logic [5:0]  in_ord_q;
  logic [4:0]  out_ord_q;
  logic signed [31:0] mean_q [MaxInOrder];
  logic signed [31:0] dev_q  [MaxInOrder];
  logic signed [31:0] mat_q  [MaxOutOrder][MaxInOrder];
  logic signed [63:0] acc_q  [MaxOutOrder];
  proj_t expect_q[$];

  localparam logic signed [63:0] AccHi = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] AccLo = -AccHi - 64'sd1;

  // standardized sample, saturated to 32 bits
  function automatic logic signed [63:0] std_sample(logic signed [31:0] x,
                                                    logic signed [31:0] m,
                                                    logic signed [31:0] sd);
    logic signed [63:0] d, q;
    d = 64'(x) - 64'(m);
    if (sd == 0) return (d > 0) ? 64'sd2147483647 : (d < 0 ? -64'sd2147483648 : 64'sd0);
    q = (d * 64'sd65536) / 64'(sd);
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q;
  endfunction

  // apply one feature beat; frame close pushes the projections
  task automatic project_feature(int col, logic signed [31:0] x);
    int ni, no;
    logic signed [63:0] s, p, a, v;
    ni = (in_ord_q < 1) ? 1 : (in_ord_q > MaxInOrder ? MaxInOrder : in_ord_q);
    no = (out_ord_q < 1) ? 1 : (out_ord_q > MaxOutOrder ? MaxOutOrder : out_ord_q);
    if (col >= ni) return;
    s = std_sample(x, mean_q[col], dev_q[col]);
    for (int k = 0; k < no; k++) begin
      p = s * 64'(mat_q[k][col]);
      a = acc_q[k] + (p >>> FracBits);
      if (a > AccHi) a = AccHi;
      if (a < AccLo) a = AccLo;
      acc_q[k] = a;
    end
    if (col == ni - 1) begin
      for (int k = 0; k < no; k++) begin
        v = acc_q[k];
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        expect_q.push_back('{idx: RowW'(k), val: v[31:0], last: (k == no - 1)});
      end
      for (int k = 0; k < MaxOutOrder; k++) acc_q[k] = '0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    proj_t e;
    if (!rst_ni) begin
      in_ord_q <= 6'd32;
      out_ord_q <= 5'd16;
      for (int k = 0; k < MaxOutOrder; k++) acc_q[k] = '0;
      expect_q.delete();
      fail_count_o <= 0;
      result_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CfgInOrder) in_ord_q <= cfg_wdata_i;
        else out_ord_q <= cfg_wdata_i[4:0];
      end
      if (in_valid_i && in_ready_i) begin
        case (mode_i)
          ModeMean: mean_q[column_index_i] = value_i;
          ModeStd: dev_q[column_index_i] = value_i;
          ModeMatrix: mat_q[row_index_i][column_index_i] = value_i;
          default: project_feature(column_index_i, value_i);
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        result_count_o <= result_count_o + 1;
        if (expect_q.size() == 0) begin
          $display("%0t: unexpected result beat idx %0d val %h", $time,
                   component_index_i, component_value_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = expect_q.pop_front();
          if (e.idx !== component_index_i || e.val !== component_value_i ||
              e.last !== last_of_frame_i) begin
            $display("%0t: mismatch expected idx %0d val %h last %0d, got idx %0d val %h last %0d",
                     $time, e.idx, e.val, e.last, component_index_i,
                     component_value_i, last_of_frame_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      // beats still owed by the block
      pending_o <= expect_q.size();
    end
  end
endmodule

// ===== dv/tb_top.sv =====
// Top of the PCA projection testbench: clock, reset, config, stimulus, verdict.
// Needs pfp_pkg, the unit and pfp_checker.
`timescale 1ns / 1ps

module tb_top;
  import pfp_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_index_i = 1'b0;
  logic [5:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] mode_i = '0;
  logic [RowW-1:0] row_index_i = '0;
  logic [ColW-1:0] column_index_i = '0;
  logic signed [31:0] value_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [RowW-1:0] component_index_o;
  logic signed [31:0] component_value_o;
  logic last_of_frame_o;
  int fail_count, pending, result_count;
  int send_idle = 0, recv_stall = 0;
  bit hold_off = 1'b0;
  int cycles = 0;
  int in_ord = 32, out_ord = 16, frames = 0;

  always #6 clk_i = ~clk_i;

  pca_feature_projection_unit dut (.*);

  pfp_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_wdata_i, .in_valid_i,
    .in_ready_i(in_ready_o), .mode_i, .row_index_i, .column_index_i, .value_i,
    .out_valid_i(out_valid_o), .out_ready_i, .component_index_i(component_index_o),
    .component_value_i(component_value_o), .last_of_frame_i(last_of_frame_o),
    .fail_count_o(fail_count), .pending_o(pending), .result_count_o(result_count)
  );

  // receiver ready, random stalls and long hold-off
  always @(posedge clk_i) begin
    if (hold_off) out_ready_i <= 1'b0;
    else out_ready_i <= ($urandom_range(99) >= recv_stall);
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // one beat, with random idle before it; valid stays up for a following beat
  task automatic send_beat(logic [1:0] m, int r, int c, logic [31:0] v);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    mode_i <= m;
    row_index_i <= RowW'(r);
    column_index_i <= ColW'(c);
    value_i <= v;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic write_cfg(logic idx, logic [5:0] d);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= d;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'($signed($urandom_range(2000)) - 1000);
      3: return 32'($signed($urandom_range(1 << 18)) - (1 << 17));
      default: return $urandom;
    endcase
  endfunction

  // load the used part of the tables with random content; some zero deviations
  task automatic load_tables(int ni, int no);
    for (int c = 0; c < ni; c++) begin
      send_beat(ModeMean, $urandom_range(15), c, rand_word());
      send_beat(ModeStd, $urandom_range(15), c,
                ($urandom_range(7) == 0) ? 32'd0 : rand_word());
    end
    for (int r = 0; r < no; r++)
      for (int c = 0; c < ni; c++)
        send_beat(ModeMatrix, r, c, rand_word());
  endtask

  task automatic wait_drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic set_orders(int ni, int no);
    in_ord = ni;
    out_ord = no;
    in_valid_i <= 1'b0;
    write_cfg(CfgInOrder, 6'(ni));
    write_cfg(CfgOutOrder, 6'(no));
    cfg_we_i <= 1'b0;
  endtask

  // one frame, sometimes with an out-of-range feature mixed in
  task automatic send_frame();
    for (int c = 0; c < in_ord; c++) begin
      if (in_ord < 32 && $urandom_range(9) == 0)
        send_beat(ModeFeature, $urandom_range(15), $urandom_range(31, in_ord), rand_word());
      send_beat(ModeFeature, $urandom_range(15), c, rand_word());
    end
    frames++;
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: extremes of orders and values, zero deviation
    load_tables(MaxInOrder, 2);
    load_tables(2, MaxOutOrder);
    send_beat(ModeStd, 0, 0, 32'd0);
    send_beat(ModeMean, 0, 0, 32'd0);
    set_orders(1, 1);
    send_beat(ModeFeature, 0, 0, 32'h7FFF_FFFF);
    send_beat(ModeFeature, 0, 0, 32'h8000_0000);
    send_beat(ModeFeature, 0, 0, 32'd0);
    send_beat(ModeFeature, 0, 5, 32'd1);
    wait_drain();
    set_orders(2, 16);
    send_frame();
    wait_drain();
    set_orders(32, 2);
    send_frame();
    wait_drain();
    load_tables(4, MaxOutOrder);
    wait_drain();
    // random phases with different idling
    for (int ph = 0; ph < 4; ph++) begin
      send_idle = (ph == 1 || ph == 3) ? ((ph == 3) ? 19 : 81) : 0;
      recv_stall = (ph == 2 || ph == 3) ? ((ph == 3) ? 19 : 81) : 0;
      set_orders($urandom_range(1, 4), (ph == 0) ? 1 : $urandom_range(1, 16));
      for (int f = 0; f < 12; f++) begin
        if (f == 6) load_tables(in_ord, out_ord);
        send_frame();
      end
      wait_drain();
    end
    // fill the block while the receiver holds off
    send_idle = 0;
    recv_stall = 0;
    set_orders(1, 16);
    hold_off = 1'b1;
    fork
      begin
        repeat (3000) @(posedge clk_i);
        hold_off = 1'b0;
      end
      for (int f = 0; f < 6; f++) send_frame();
    join
    wait_drain();
    $display("Covered %0d frames, %0d result beats, orders from 1 to 32,", frames,
             result_count);
    $display("zero deviations, saturating values and stall phases.");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/pfp_pkg.sv
rtl/core/pfp_ram.sv
rtl/core/pfp_cell.sv
rtl/core/pfp_div.sv
rtl/core/pca_feature_projection_unit.sv
dv/pfp_checker.sv
dv/tb_top.sv
